>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FXTV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fxtv check failed");
`define FXTV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fxtv check failed");
`else
`define FXTV_ASSERT(lbl, clk, rst_n, prop)
`define FXTV_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/fxtv_pkg.sv
// ---------------------------------------------------------------------------
// fxtv_pkg
// shared constants and types of the tag=value field decoder
// ---------------------------------------------------------------------------
package fxtv_pkg;

  localparam int MAX_MSG_BYTES = 4096;
  localparam int POS_W         = $clog2(MAX_MSG_BYTES + 1);
  localparam int OFF_W         = $clog2(MAX_MSG_BYTES);
  localparam int TAG_W         = 20;
  localparam int UINT_W        = 64;
  localparam int FRAC_W        = 7;
  localparam int DELIM_W       = 8;
  localparam int SCALE_W       = 20;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 20;
  localparam int Q_DEPTH       = 4;

  localparam logic [TAG_W-1:0]   TAG_SAT       = TAG_W'(999999);
  localparam logic [TAG_W-1:0]   TAG_MSGTYPE   = TAG_W'(35);
  localparam logic [7:0]         CH_EQUALS     = 8'h3d;
  localparam logic [7:0]         CH_MINUS      = 8'h2d;
  localparam logic [7:0]         CH_POINT      = 8'h2e;
  localparam logic [7:0]         CH_ZERO       = 8'h30;
  localparam logic [7:0]         CH_NINE       = 8'h39;
  localparam logic [DELIM_W-1:0] DELIM_RESET   = DELIM_W'(1);
  localparam logic [SCALE_W-1:0] SCALE_RESET   = SCALE_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_DELIMITER = 1'b0,
    CFG_SCALE_FACTOR    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              has_field;
    logic [TAG_W-1:0]  field_tag;
    logic [UINT_W-1:0] unsigned_value;
    logic [UINT_W-1:0] int_part;
    logic [FRAC_W-1:0] frac;
    logic              is_negative;
    logic [OFF_W-1:0]  value_offset;
    logic [POS_W-1:0]  value_length;
    logic              msg_end;
    logic              msg_valid;
    logic              tag_error;
  } rec_t;

  typedef struct packed {
    logic                     has_field;
    logic [TAG_W-1:0]         field_tag;
    logic [UINT_W-1:0]        unsigned_value;
    logic signed [UINT_W-1:0] price_value;
    logic [OFF_W-1:0]         value_offset;
    logic [POS_W-1:0]         value_length;
    logic                     msg_end;
    logic                     msg_valid;
    logic                     tag_error;
  } res_t;

endpackage

>>> rtl/fxtv_front.sv
// ---------------------------------------------------------------------------
// fxtv_front
// byte parser: tag and value tracking, accumulators, field records
// ---------------------------------------------------------------------------
module fxtv_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_msg_byte,
  input  logic                           in_msg_last,
  input  logic [fxtv_pkg::DELIM_W-1:0]   field_delimiter,
  input  logic                           q_full,
  output logic                           push,
  output fxtv_pkg::rec_t                 push_rec
);
  import fxtv_pkg::*;

  function automatic logic [UINT_W-1:0] times10_add(input logic [UINT_W-1:0] a,
                                                   input logic [3:0] d);
    times10_add = {a[UINT_W-4:0], 3'b000} + {a[UINT_W-2:0], 1'b0} + {60'd0, d};
  endfunction

  logic              in_value_r, in_value_nxt;
  logic              bad_r, bad_nxt;
  logic              pend_r, pend_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [UINT_W-1:0] uint_r, uint_nxt;
  logic              ustop_r, ustop_nxt;
  logic [UINT_W-1:0] ipart_r, ipart_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [1:0]        fcnt_r, fcnt_nxt;
  logic              point_r, point_nxt;
  logic              neg_r, neg_nxt;
  logic              pstop_r, pstop_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [OFF_W-1:0]  vbegin_r, vbegin_nxt;
  logic [POS_W-1:0]  vcnt_r, vcnt_nxt;
  logic              mtype_r, mtype_nxt;

  logic              accept;
  logic              emit;
  logic              is_digit;
  logic [3:0]        dval;
  logic [POS_W-1:0]  pos_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_digit = (in_msg_byte >= CH_ZERO) && (in_msg_byte <= CH_NINE);
  assign dval     = in_msg_byte[3:0];
  assign pos_inc  = pos_r + POS_W'(1);

  always_comb begin
    in_value_nxt = in_value_r;
    bad_nxt      = bad_r;
    pend_nxt     = pend_r;
    tag_nxt      = tag_r;
    uint_nxt     = uint_r;
    ustop_nxt    = ustop_r;
    ipart_nxt    = ipart_r;
    frac_nxt     = frac_r;
    fcnt_nxt     = fcnt_r;
    point_nxt    = point_r;
    neg_nxt      = neg_r;
    pstop_nxt    = pstop_r;
    pos_nxt      = pos_r;
    vbegin_nxt   = vbegin_r;
    vcnt_nxt     = vcnt_r;
    mtype_nxt    = mtype_r;
    emit         = 1'b0;
    push         = 1'b0;
    push_rec     = '0;

    if (accept) begin
      pos_nxt = (pos_r < POS_W'(MAX_MSG_BYTES)) ? pos_inc : POS_W'(MAX_MSG_BYTES);
      if (!bad_r) begin
        if (!in_value_r) begin
          if (in_msg_byte == CH_EQUALS) begin
            if (pend_r) begin
              bad_nxt = 1'b1;
            end else begin
              in_value_nxt = 1'b1;
              uint_nxt     = '0;
              ustop_nxt    = 1'b0;
              ipart_nxt    = '0;
              frac_nxt     = '0;
              fcnt_nxt     = '0;
              point_nxt    = 1'b0;
              neg_nxt      = 1'b0;
              pstop_nxt    = 1'b0;
              vcnt_nxt     = '0;
              vbegin_nxt   = (pos_inc < POS_W'(MAX_MSG_BYTES)) ? pos_inc[OFF_W-1:0]
                                                              : OFF_W'(MAX_MSG_BYTES - 1);
              emit         = in_msg_last;
            end
          end else if (is_digit) begin
            if (({4'd0, tag_r} << 3) + ({4'd0, tag_r} << 1) + (TAG_W+4)'(dval)
                > (TAG_W+4)'(TAG_SAT)) begin
              tag_nxt = TAG_SAT;
            end else begin
              tag_nxt = TAG_W'(({4'd0, tag_r} << 3) + ({4'd0, tag_r} << 1)
                               + (TAG_W+4)'(dval));
            end
          end else begin
            pend_nxt = 1'b1;
          end
        end else if (in_msg_byte == field_delimiter) begin
          emit = 1'b1;
        end else begin
          emit = in_msg_last;
          if (vcnt_r < POS_W'(MAX_MSG_BYTES)) begin
            vcnt_nxt = vcnt_r + POS_W'(1);
          end
          if (!ustop_r) begin
            if (is_digit) begin
              uint_nxt = times10_add(uint_r, dval);
            end else begin
              ustop_nxt = 1'b1;
            end
          end
          if ((vcnt_r == '0) && (in_msg_byte == CH_MINUS)) begin
            neg_nxt = 1'b1;
          end else if (!pstop_r) begin
            if (in_msg_byte == CH_POINT) begin
              point_nxt = 1'b1;
            end else if (!is_digit) begin
              pstop_nxt = 1'b1;
            end else if (point_r) begin
              if (fcnt_r < 2'd2) begin
                frac_nxt = FRAC_W'({frac_r, 3'b000} + {2'b00, frac_r, 1'b0} + {6'd0, dval});
                fcnt_nxt = fcnt_r + 2'd1;
              end
            end else begin
              ipart_nxt = times10_add(ipart_r, dval);
            end
          end
        end
      end

      if (emit) begin
        push_rec.has_field      = 1'b1;
        push_rec.field_tag      = tag_nxt;
        push_rec.unsigned_value = uint_nxt;
        push_rec.int_part       = ipart_nxt;
        case (fcnt_nxt)
          2'd1:    push_rec.frac = FRAC_W'({frac_nxt, 3'b000} + {2'b00, frac_nxt, 1'b0});
          2'd2:    push_rec.frac = frac_nxt;
          default: push_rec.frac = '0;
        endcase
        push_rec.is_negative    = neg_nxt;
        push_rec.value_offset   = vbegin_nxt;
        push_rec.value_length   = vcnt_nxt;
        if (tag_nxt == TAG_MSGTYPE) begin
          mtype_nxt = (vcnt_nxt != '0);
        end
        in_value_nxt = 1'b0;
        tag_nxt      = '0;
        pend_nxt     = 1'b0;
      end

      if (in_msg_last) begin
        push_rec.msg_end   = 1'b1;
        push_rec.msg_valid = !bad_nxt && mtype_nxt;
        push_rec.tag_error = bad_nxt;
        in_value_nxt = 1'b0;
        bad_nxt      = 1'b0;
        pend_nxt     = 1'b0;
        tag_nxt      = '0;
        uint_nxt     = '0;
        ustop_nxt    = 1'b0;
        ipart_nxt    = '0;
        frac_nxt     = '0;
        fcnt_nxt     = '0;
        point_nxt    = 1'b0;
        neg_nxt      = 1'b0;
        pstop_nxt    = 1'b0;
        pos_nxt      = '0;
        vbegin_nxt   = '0;
        vcnt_nxt     = '0;
        mtype_nxt    = 1'b0;
      end

      push = emit || in_msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r <= 1'b0;
      bad_r      <= 1'b0;
      pend_r     <= 1'b0;
      tag_r      <= '0;
      uint_r     <= '0;
      ustop_r    <= 1'b0;
      ipart_r    <= '0;
      frac_r     <= '0;
      fcnt_r     <= '0;
      point_r    <= 1'b0;
      neg_r      <= 1'b0;
      pstop_r    <= 1'b0;
      pos_r      <= '0;
      vbegin_r   <= '0;
      vcnt_r     <= '0;
      mtype_r    <= 1'b0;
    end else begin
      in_value_r <= in_value_nxt;
      bad_r      <= bad_nxt;
      pend_r     <= pend_nxt;
      tag_r      <= tag_nxt;
      uint_r     <= uint_nxt;
      ustop_r    <= ustop_nxt;
      ipart_r    <= ipart_nxt;
      frac_r     <= frac_nxt;
      fcnt_r     <= fcnt_nxt;
      point_r    <= point_nxt;
      neg_r      <= neg_nxt;
      pstop_r    <= pstop_nxt;
      pos_r      <= pos_nxt;
      vbegin_r   <= vbegin_nxt;
      vcnt_r     <= vcnt_nxt;
      mtype_r    <= mtype_nxt;
    end
  end

endmodule

>>> rtl/fxtv_queue.sv
// ---------------------------------------------------------------------------
// fxtv_queue
// small record queue between parser and price pipeline
// ---------------------------------------------------------------------------
module fxtv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fxtv_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output fxtv_pkg::rec_t pop_rec,
  output logic           not_empty
);
  import fxtv_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  rec_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/fxtv_back.sv
// ---------------------------------------------------------------------------
// fxtv_back
// price pipeline: split multiply, sum, sign, output register
// ---------------------------------------------------------------------------
module fxtv_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [fxtv_pkg::SCALE_W-1:0] scale_factor,
  input  logic                         q_not_empty,
  input  fxtv_pkg::rec_t               q_rec,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fxtv_pkg::res_t               out_res
);
  import fxtv_pkg::*;

  localparam int HALF_W = UINT_W / 2;
  localparam int PLO_W  = HALF_W + SCALE_W;

  logic              s1_v_r, s2_v_r, s3_v_r;
  rec_t              s1_rec_r, s2_rec_r;
  logic [PLO_W-1:0]  s1_plo_r;
  logic [HALF_W-1:0] s1_phi_r;
  logic [UINT_W-1:0] s2_sum_r;
  res_t              s3_res_r;
  logic [PLO_W-1:0]  plo_nxt;
  logic [PLO_W-1:0]  phi_full;
  logic [UINT_W-1:0] sum_nxt;
  res_t              res_nxt;
  logic              s1_free, s2_free, s3_free;

  assign s3_free = !s3_v_r || !out_stall;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_free = !s1_v_r || s2_free;
  assign q_pop   = q_not_empty && s1_free;

  assign plo_nxt  = {{SCALE_W{1'b0}}, q_rec.int_part[HALF_W-1:0]}
                  * {{HALF_W{1'b0}}, scale_factor};
  assign phi_full = {{SCALE_W{1'b0}}, q_rec.int_part[UINT_W-1:HALF_W]}
                  * {{HALF_W{1'b0}}, scale_factor};

  assign sum_nxt = {{(UINT_W-PLO_W){1'b0}}, s1_plo_r} + {s1_phi_r, {HALF_W{1'b0}}}
                 + {{(UINT_W-FRAC_W){1'b0}}, s1_rec_r.frac};

  always_comb begin
    res_nxt.has_field      = s2_rec_r.has_field;
    res_nxt.field_tag      = s2_rec_r.field_tag;
    res_nxt.unsigned_value = s2_rec_r.unsigned_value;
    res_nxt.price_value    = s2_rec_r.is_negative ? -s2_sum_r : s2_sum_r;
    res_nxt.value_offset   = s2_rec_r.value_offset;
    res_nxt.value_length   = s2_rec_r.value_length;
    res_nxt.msg_end        = s2_rec_r.msg_end;
    res_nxt.msg_valid      = s2_rec_r.msg_valid;
    res_nxt.tag_error      = s2_rec_r.tag_error;
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_rec_r <= q_rec;
      s1_plo_r <= plo_nxt;
      s1_phi_r <= phi_full[HALF_W-1:0];
    end
    if (s2_free) begin
      s2_rec_r <= s1_rec_r;
      s2_sum_r <= sum_nxt;
    end
    if (s3_free) begin
      s3_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= q_pop;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid = s3_v_r;
  assign out_res   = s3_res_r;

endmodule

>>> rtl/fix_tag_value_field_decoder.sv
// each result passes the record queue, then price stages s1, s2 and s3, plus any queue wait
// throughput: one byte per cycle while in_stall is low; the split 64x20 price multiply is pipelined
// bytes that complete no field and are not last produce no result
// in_stall rises only while the 4-entry record queue is full
// synchronous active-low reset clears parser state, queue and pipeline
// configuration registers reset to delimiter 1 and price scale 100
// ---------------------------------------------------------------------------
// fix_tag_value_field_decoder
// tag=value field decoder top: configuration, parser, queue, price pipeline
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fix_tag_value_field_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fxtv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fxtv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_msg_byte,
  input  logic                             in_msg_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_has_field,
  output logic [fxtv_pkg::TAG_W-1:0]       out_field_tag,
  output logic [fxtv_pkg::UINT_W-1:0]      out_unsigned_value,
  output logic signed [fxtv_pkg::UINT_W-1:0] out_price_value,
  output logic [fxtv_pkg::OFF_W-1:0]       out_value_offset,
  output logic [fxtv_pkg::POS_W-1:0]       out_value_length,
  output logic                             out_msg_end,
  output logic                             out_msg_valid,
  output logic                             out_tag_error
);
  import fxtv_pkg::*;

  logic [DELIM_W-1:0] delim_r;
  logic [SCALE_W-1:0] scale_r;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_not_empty;
  rec_t               push_rec;
  rec_t               pop_rec;
  res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIELD_DELIMITER: delim_r <= cfg_wdata[DELIM_W-1:0];
        CFG_SCALE_FACTOR:    scale_r <= cfg_wdata[SCALE_W-1:0];
        default:             delim_r <= delim_r;
      endcase
    end
  end

  fxtv_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_msg_byte     (in_msg_byte),
    .in_msg_last     (in_msg_last),
    .field_delimiter (delim_r),
    .q_full          (q_full),
    .push            (q_push),
    .push_rec        (push_rec)
  );

  fxtv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_rec   (pop_rec),
    .not_empty (q_not_empty)
  );

  fxtv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .scale_factor (scale_r),
    .q_not_empty  (q_not_empty),
    .q_rec        (pop_rec),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_has_field      = res.has_field;
  assign out_field_tag      = res.field_tag;
  assign out_unsigned_value = res.unsigned_value;
  assign out_price_value    = res.price_value;
  assign out_value_offset   = res.value_offset;
  assign out_value_length   = res.value_length;
  assign out_msg_end        = res.msg_end;
  assign out_msg_valid      = res.msg_valid;
  assign out_tag_error      = res.tag_error;

  `FXTV_ASSERT(a_end_flags_only_at_end, clk, rst_n, out_valid && !out_msg_end |-> !out_msg_valid && !out_tag_error)
  `FXTV_ASSERT(a_valid_excludes_error, clk, rst_n, out_valid && out_msg_valid |-> !out_tag_error)
  `FXTV_ASSERT(a_fieldless_is_zero, clk, rst_n, out_valid && !out_has_field |-> out_unsigned_value == '0 && out_value_length == '0 && out_field_tag == '0)
  `FXTV_ASSERT(a_no_push_when_full, clk, rst_n, q_full |-> in_stall)

endmodule
